/* rtl/exp_table_interpolator_top_assert.svh */
// assertion macros used by the top-level rtl
`ifndef EXP_TABLE_INTERPOLATOR_TOP_ASSERT_SVH
`define EXP_TABLE_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ETI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ETI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ETI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ETI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/eti_pkg.sv */
package eti_pkg;

	localparam int SAMPLES = 2048;
	localparam int BANKS   = 4;
	localparam int IDX_W   = $clog2(SAMPLES);
	localparam int BANK_W  = $clog2(BANKS);
	localparam int ADDR_W  = BANK_W + IDX_W;
	localparam int HALF_W  = ADDR_W - 1;
	localparam int HALF_DEPTH = (BANKS * SAMPLES) / 2;
	localparam int DATA_W  = 32;
	localparam int NREGS   = 8;
	localparam int REG_IDX_W = $clog2(NREGS);
	localparam int PADDR_W = REG_IDX_W + 2;

	localparam logic [DATA_W-1:0] INV_RESET = 32'h0001_0000;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_START_0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_INV_0   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INV_3   = 3'd7;

	typedef struct packed {
		logic [BANKS-1:0][DATA_W-1:0] start;
		logic [BANKS-1:0][DATA_W-1:0] inv_step;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [HALF_W-1:0] raddr_even;
		logic [HALF_W-1:0] raddr_odd;
	} mem_req_t;

endpackage

/* rtl/eti_cfg.sv */
module eti_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [eti_pkg::PADDR_W-1:0]    paddr,
	input  logic [eti_pkg::DATA_W-1:0]     pwdata,
	output logic [eti_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	output eti_pkg::cfg_t                  cfg
);
	import eti_pkg::*;

	logic [BANKS-1:0][DATA_W-1:0] start_q;
	logic [BANKS-1:0][DATA_W-1:0] inv_q;
	logic [REG_IDX_W-1:0]         reg_idx;
	logic                         wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANKS; i++) begin
				start_q[i] <= '0;
				inv_q[i]   <= INV_RESET;
			end
		end else if (wr_en) begin
			unique case (reg_idx) inside
				[REG_START_0:REG_START_3]: start_q[reg_idx[BANK_W-1:0]] <= pwdata;
				[REG_INV_0:REG_INV_3]:     inv_q[reg_idx[BANK_W-1:0]]   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx) inside
			[REG_START_0:REG_START_3]: prdata = start_q[reg_idx[BANK_W-1:0]];
			[REG_INV_0:REG_INV_3]:     prdata = inv_q[reg_idx[BANK_W-1:0]];
			default:                   prdata = '0;
		endcase
	end

	assign cfg.start    = start_q;
	assign cfg.inv_step = inv_q;

endmodule

/* rtl/eti_mem.sv */
module eti_mem (
	input  logic                       clk,
	input  eti_pkg::mem_req_t          req,
	output logic [eti_pkg::DATA_W-1:0] rd_even,
	output logic [eti_pkg::DATA_W-1:0] rd_odd
);
	import eti_pkg::*;

	// even and odd sample slots live apart so a bin and its neighbor read together
	logic [DATA_W-1:0] mem_even_q [HALF_DEPTH];
	logic [DATA_W-1:0] mem_odd_q  [HALF_DEPTH];
	logic [DATA_W-1:0] rd_even_q;
	logic [DATA_W-1:0] rd_odd_q;

	always_ff @(posedge clk) begin
		if (req.we && !req.waddr[0])
			mem_even_q[req.waddr[ADDR_W-1:1]] <= req.wdata;
		if (req.re)
			rd_even_q <= mem_even_q[req.raddr_even];
	end

	always_ff @(posedge clk) begin
		if (req.we && req.waddr[0])
			mem_odd_q[req.waddr[ADDR_W-1:1]] <= req.wdata;
		if (req.re)
			rd_odd_q <= mem_odd_q[req.raddr_odd];
	end

	assign rd_even = rd_even_q;
	assign rd_odd  = rd_odd_q;

endmodule

/* rtl/exp_table_interpolator_top.sv */
// channel  | handshake                | payload
// config   | psel penable pwrite      | paddr pwdata prdata, pready tied high
// request  | in_valid in_stall        | operation bank sample_slot sample_value position
// result   | out_valid out_stall      | value out_of_range
//
// one request per cycle sustained while out_stall stays low; a lookup result passes through every stage below
// stages: offset, 32x32 scale, sample read, blend multiply, sum into output register
// loads write the sample store in the read stage and give no result
// each stage holds only while the one after it is full and held, bubbles are squeezed out
// arst_n clears control and config; the sample store is not cleared and needs no pass
`include "exp_table_interpolator_top_assert.svh"

module exp_table_interpolator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [eti_pkg::PADDR_W-1:0] paddr,
	input  logic [eti_pkg::DATA_W-1:0]  pwdata,
	output logic [eti_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [1:0]                  bank,
	input  logic [10:0]                 sample_slot,
	input  logic [31:0]                 sample_value,
	input  logic signed [31:0]          position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 value,
	output logic                        out_of_range
);
	import eti_pkg::*;

	cfg_t     cfg;
	mem_req_t mem_req;
	logic [DATA_W-1:0] rd_even;
	logic [DATA_W-1:0] rd_odd;

	logic en1, en2, en3, en4, en_out;

	// stage 1
	logic                v_s1;
	logic                op_s1;
	logic [BANK_W-1:0]   bank_s1;
	logic [IDX_W-1:0]    slot_s1;
	logic [DATA_W-1:0]   sval_s1;
	logic [DATA_W:0]     d_s1;
	logic [DATA_W-1:0]   inv_s1;
	logic [DATA_W:0]     d_in;

	// stage 2
	logic                v_s2;
	logic                op_s2;
	logic [BANK_W-1:0]   bank_s2;
	logic [IDX_W-1:0]    slot_s2;
	logic [DATA_W-1:0]   sval_s2;
	logic                neg_s2;
	logic [2*DATA_W-1:0] p_s2;
	logic [IDX_W-1:0]    idx;
	logic                oor;
	logic                edge_bin;
	logic [ADDR_W-1:0]   raddr;

	// stage 3
	logic                v_s3;
	logic                oor_s3;
	logic                edge_s3;
	logic                odd_s3;
	logic [15:0]         f_s3;
	logic [DATA_W-1:0]   s0;
	logic [DATA_W-1:0]   s1;
	logic signed [DATA_W:0]   diff;
	logic signed [DATA_W+17:0] prod;

	// stage 4
	logic                v_s4;
	logic                oor_s4;
	logic [DATA_W-1:0]   base_s4;
	logic signed [DATA_W+17:0] prod_s4;
	logic signed [DATA_W+17:0] sum;

	logic                out_valid_q;
	logic [DATA_W-1:0]   value_q;
	logic                oor_q;

	eti_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	eti_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_even (rd_even),
		.rd_odd  (rd_odd)
	);

	assign en_out = !out_valid_q || !out_stall;
	assign en4    = !v_s4 || en_out;
	assign en3    = !v_s3 || en4;
	assign en2    = !v_s2 || op_s2 == OP_LOAD || en3;
	assign en1    = !v_s1 || en2;
	assign in_stall = !en1;

	assign d_in = {position[31], position} - {cfg.start[bank][31], cfg.start[bank]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en1)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1   <= operation;
			bank_s1 <= bank;
			slot_s1 <= sample_slot;
			sval_s1 <= sample_value;
			d_s1    <= d_in;
			inv_s1  <= cfg.inv_step[bank];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2   <= op_s1;
			bank_s2 <= bank_s1;
			slot_s2 <= slot_s1;
			sval_s2 <= sval_s1;
			neg_s2  <= d_s1[DATA_W];
			p_s2    <= (2*DATA_W)'(d_s1[DATA_W-1:0]) * (2*DATA_W)'(inv_s1);
		end
	end

	assign idx      = p_s2[DATA_W +: IDX_W];
	assign oor      = neg_s2 || (|p_s2[2*DATA_W-1:DATA_W+IDX_W]);
	assign edge_bin = idx == '0 || idx == IDX_W'(SAMPLES - 1);
	assign raddr    = {bank_s2, idx};

	always_comb begin
		mem_req.we         = v_s2 && op_s2 == OP_LOAD;
		mem_req.waddr      = {bank_s2, slot_s2};
		mem_req.wdata      = sval_s2;
		mem_req.re         = en3;
		mem_req.raddr_odd  = raddr[ADDR_W-1:1];
		mem_req.raddr_even = raddr[ADDR_W-1:1] + HALF_W'(raddr[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en3)
			v_s3 <= v_s2 && op_s2 == OP_LOOKUP;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			oor_s3  <= oor;
			edge_s3 <= edge_bin;
			odd_s3  <= idx[0];
			f_s3    <= p_s2[31:16];
		end
	end

	assign s0   = odd_s3 ? rd_odd : rd_even;
	assign s1   = odd_s3 ? rd_even : rd_odd;
	assign diff = edge_s3 ? '0 : $signed({1'b0, s1}) - $signed({1'b0, s0});
	assign prod = (DATA_W+18)'(diff) * (DATA_W+18)'($signed({1'b0, f_s3}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			oor_s4  <= oor_s3;
			base_s4 <= s0;
			prod_s4 <= prod;
		end
	end

	// s0 + floor((s1 - s0) * f / 2^16) equals the truncated two-sided blend
	assign sum = $signed({18'd0, base_s4}) + (prod_s4 >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en_out)
			out_valid_q <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			oor_q   <= oor_s4;
			value_q <= oor_s4 ? '0 : sum[DATA_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign out_of_range = oor_q;

	`ETI_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, v_s1)
	`ETI_ASSERT_NEXT(a_load_no_result, clk, arst_n, v_s2 && op_s2 == OP_LOAD && en3, !v_s3)
	`ETI_ASSERT_NEXT(a_read_held, clk, arst_n, v_s3 && !en3, $stable(rd_even) && $stable(rd_odd))
	`ETI_ASSERT_IMP(a_oor_zero, clk, arst_n, out_valid_q && oor_q, value_q == '0)

endmodule
